@@ hdl/bpa_pkg.sv @@
// Shared constants for the bitmap page allocator: map geometry, field widths,
// request and status codes. Used by the top level; depends on nothing.
package bpa_pkg;

	// Map geometry.
	localparam int WORD_COUNT = 512;
	localparam int WORD_BITS  = 64;
	localparam int MAX_RUN    = 16;

	localparam int ADDR_W   = $clog2(WORD_COUNT);
	localparam int BIT_W    = $clog2(WORD_BITS);
	localparam int PAGE_W   = 15;
	localparam int COUNT_W  = 5;
	localparam int RUN_W    = $clog2(MAX_RUN + 1);

	// The lowest clear bit is found a byte group first, then a bit within it.
	localparam int GRP_BITS = 8;
	localparam int GROUPS   = WORD_BITS / GRP_BITS;
	localparam int GRP_W    = $clog2(GROUPS);
	localparam int SUB_W    = $clog2(GRP_BITS);

	// Request codes.
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RESERVE = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// Status codes.
	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;

endpackage

@@ hdl/bpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bitmap_page_allocator_top.sv @@
// First-fit bitmap page allocator: sequencer, scan hint and output register.
// Depends on bpa_pkg and bpa_ram.
//
// Usage:
// Requests enter on in_valid/in_ready with action, page_number and page_count;
// results leave on out_valid/out_ready with granted_page, status and last.
// An allocate request yields one result per page granted (up to 16), the last
// one marked; a full map ends the run with status 1, and a count of zero gives
// a single result with status 2. Reserve and release give one echo result.
// After reset the block sweeps the 512-word map to zero, one word a cycle, and
// holds in_ready low until the sweep is done.
// Sequence: a reserve or release reads the map word, then updates it and loads
// its result. Each granted page takes a map read, a word test and a bit set,
// and each full word skipped adds a map read and word test; a kept pointer to
// the lowest word that may hold a free page means full words at the bottom of
// the map are skipped unread. The single map read port sets these steps.
// A new request is accepted only when the previous one has finished; the last
// result may still be waiting in the output register. When the receiver
// stalls, the sequencer holds before each result and makes no map change
// until the output register is free.
module bitmap_page_allocator_top
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [PAGE_W-1:0] page_number,
	input  logic [COUNT_W-1:0] page_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PAGE_W-1:0] granted_page,
	output logic [1:0]        status,
	output logic              last
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_EVAL  = 4'd3;
	localparam logic [3:0] S_BIT   = 4'd4;
	localparam logic [3:0] S_MOD   = 4'd5;
	localparam logic [3:0] S_ZERO  = 4'd6;
	localparam logic [3:0] S_FULL  = 4'd7;

	logic [3:0]           state_q;
	logic [ADDR_W-1:0]    clr_q;
	logic [ADDR_W-1:0]    hint_q;
	logic [ADDR_W-1:0]    scan_q;
	logic [1:0]           act_q;
	logic [PAGE_W-1:0]    page_q;
	logic                 inr_q;
	logic [RUN_W-1:0]     run_q;
	logic [WORD_BITS-1:0] word_q;
	logic [GRP_W-1:0]     grp_q;
	logic                 out_valid_q;
	logic [PAGE_W-1:0]    out_page_q;
	logic [1:0]           out_status_q;
	logic                 out_last_q;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 out_free;
	logic                 out_load;
	logic                 accept;
	logic [GRP_W-1:0]     grp_sel;
	logic [SUB_W-1:0]     sub_sel;
	logic [GRP_BITS-1:0]  grp_byte;
	logic [WORD_BITS-1:0] page_bit;
	logic [WORD_BITS-1:0] grant_bit;
	logic [ADDR_W-1:0]    req_word;
	logic                 req_inr;
	logic [RUN_W-1:0]     req_run;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// A result is loaded whenever a result state finds the output register free.
	assign out_load  = out_free && (state_q inside {S_BIT, S_MOD, S_ZERO, S_FULL});

	assign out_valid    = out_valid_q;
	assign granted_page = out_page_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

	// Word index of a named page, its range check and the saturated run length.
	assign req_word = ADDR_W'(page_number >> BIT_W);
	assign req_inr  = (int'(page_number >> BIT_W) < WORD_COUNT);
	assign req_run  = (int'(page_count) > MAX_RUN) ? RUN_W'(MAX_RUN) : RUN_W'(page_count);

	// Find the first byte group of the fetched word that has a clear bit.
	always_comb begin
		grp_sel = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (!(&ram_rdata[g*GRP_BITS +: GRP_BITS])) begin
				grp_sel = GRP_W'(g);
			end
		end
	end

	// Find the lowest clear bit within the chosen group.
	assign grp_byte = word_q[grp_q*GRP_BITS +: GRP_BITS];
	always_comb begin
		sub_sel = '0;
		for (int s = GRP_BITS - 1; s >= 0; s--) begin
			if (!grp_byte[s]) begin
				sub_sel = SUB_W'(s);
			end
		end
	end

	assign grant_bit = WORD_BITS'(1) << {grp_q, sub_sel};
	assign page_bit  = WORD_BITS'(1) << page_q[BIT_W-1:0];

	// Map write port: clearing sweep, page grant or named-page update.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = scan_q;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_BIT: begin
				ram_we    = out_free;
				ram_wdata = word_q | grant_bit;
			end
			S_MOD: begin
				ram_we    = out_free && inr_q;
				ram_wdata = (act_q == ACT_RESERVE) ? (ram_rdata | page_bit)
					: (ram_rdata & ~page_bit);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_q),
		.rdata(ram_rdata)
	);

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(WORD_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_ALLOC) begin
							state_q <= (page_count == '0) ? S_ZERO : S_READ;
						end else if (action inside {ACT_RESERVE, ACT_RELEASE}) begin
							state_q <= req_inr ? S_READ : S_MOD;
						end
					end
				end
				S_READ: begin
					state_q <= (act_q == ACT_ALLOC) ? S_EVAL : S_MOD;
				end
				S_EVAL: begin
					if (&ram_rdata) begin
						if (scan_q == ADDR_W'(WORD_COUNT - 1)) begin
							state_q <= S_FULL;
						end else begin
							hint_q  <= scan_q + 1'b1;
							state_q <= S_READ;
						end
					end else begin
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					if (out_free) begin
						state_q <= (run_q == RUN_W'(1)) ? S_IDLE : S_READ;
					end
				end
				S_MOD: begin
					if (out_free) begin
						if (inr_q && act_q == ACT_RELEASE && scan_q < hint_q) begin
							hint_q <= scan_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_ZERO, S_FULL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, scan and result payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					act_q  <= action;
					page_q <= page_number;
					inr_q  <= req_inr;
					run_q  <= req_run;
					scan_q <= (action == ACT_ALLOC) ? hint_q : req_word;
				end
			end
			S_EVAL: begin
				word_q <= ram_rdata;
				grp_q  <= grp_sel;
				if ((&ram_rdata) && scan_q != ADDR_W'(WORD_COUNT - 1)) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			S_BIT: begin
				if (out_free) begin
					out_page_q   <= PAGE_W'({scan_q, grp_q, sub_sel});
					out_status_q <= STATUS_DONE;
					out_last_q   <= (run_q == RUN_W'(1));
					run_q        <= run_q - 1'b1;
				end
			end
			S_MOD: begin
				if (out_free) begin
					out_page_q   <= page_q;
					out_status_q <= STATUS_DONE;
					out_last_q   <= 1'b1;
				end
			end
			S_ZERO: begin
				if (out_free) begin
					out_page_q   <= '0;
					out_status_q <= STATUS_ZERO;
					out_last_q   <= 1'b1;
				end
			end
			S_FULL: begin
				if (out_free) begin
					out_page_q   <= '0;
					out_status_q <= STATUS_FULL;
					out_last_q   <= 1'b1;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

endmodule
